/* design/lfu_pkg.sv */
`default_nettype none
package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_W          = 5;
    localparam int KEY_W          = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic match;
        logic update;
        logic scan;
        logic evict;
        logic insert;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cap_zero;
        logic hit;
        logic is_put;
        logic scan_last;
        logic out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

/* design/lfu_if.sv */
`default_nettype none
interface lfu_req_if;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [31:0]       key;
    logic signed [31:0]       value;
    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [31:0]       read_value;
    logic                     evicted;
    logic signed [31:0]       evicted_key;
    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

interface lfu_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [4:0]               data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/lfu_ctrl.sv */
`default_nettype none
module lfu_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lfu_pkg::dp_stat_t stat,
    output lfu_pkg::dp_cmd_t      cmd
);
    import lfu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MATCH, S_UPDATE, S_SCAN, S_EVICT, S_INSERT, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch_in = in_valid;
                if (in_valid)
                    state_next = S_MATCH;
            end
            S_MATCH:
            begin
                cmd.match = 1'b1;
                priority if (stat.cap_zero)
                    state_next = S_DONE;
                else if (stat.hit)
                    state_next = S_UPDATE;
                else if (stat.is_put)
                    state_next = S_SCAN;
                else
                    state_next = S_DONE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                    state_next = S_EVICT;
            end
            S_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* design/lfu_datapath.sv */
`default_nettype none
module lfu_datapath #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lfu_pkg::dp_cmd_t  cmd,
    output lfu_pkg::dp_stat_t      stat,
    input  wire logic              cfg_we,
    input  wire logic [lfu_pkg::CAP_W-1:0] cfg_data,
    input  wire logic              in_cmd,
    input  wire logic [lfu_pkg::KEY_W-1:0] in_key,
    input  wire logic [lfu_pkg::KEY_W-1:0] in_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_hit,
    output logic [lfu_pkg::KEY_W-1:0] out_read_value,
    output logic                   out_evicted,
    output logic [lfu_pkg::KEY_W-1:0] out_evicted_key
);
    import lfu_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);

    logic [CAP_W-1:0]      cap_reg;
    logic [OCC_W-1:0]      occ_reg;

    logic                  slot_valid_reg [ENTRIES];
    logic [KEY_W-1:0]      slot_key_reg   [ENTRIES];
    logic [KEY_W-1:0]      slot_val_reg   [ENTRIES];
    logic [COUNT_BITS-1:0] slot_cnt_reg   [ENTRIES];
    logic [IDX_W-1:0]      slot_rank_reg  [ENTRIES];

    logic                  cmd_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      val_reg;

    logic [ENTRIES-1:0]    match_vec, match_reg;
    logic [IDX_W-1:0]      hit_rank, hit_rank_reg;
    logic [KEY_W-1:0]      hit_val;

    logic [IDX_W-1:0]      scan_idx_reg;
    logic                  vic_found_reg;
    logic [IDX_W-1:0]      vic_idx_reg;
    logic [COUNT_BITS-1:0] vic_cnt_reg;
    logic [IDX_W-1:0]      vic_rank_reg;
    logic [KEY_W-1:0]      vic_key_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;

    logic                  res_hit_reg, res_ev_reg;
    logic [KEY_W-1:0]      res_rd_reg, res_evkey_reg;

    logic [CMP_W-1:0]      cap_eff;
    logic                  need_evict;
    logic                  do_evict;
    logic                  better;

    assign cap_eff    = (CMP_W'(cap_reg) > ENTRIES_C) ? ENTRIES_C : CMP_W'(cap_reg);
    assign need_evict = CMP_W'(occ_reg) >= cap_eff;
    assign do_evict   = need_evict && vic_found_reg;

    always_comb
    begin
        hit_rank = '0;
        hit_val  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = slot_valid_reg[i] && (slot_key_reg[i] == key_reg);
            if (match_vec[i])
                hit_rank = hit_rank | slot_rank_reg[i];
            if (match_reg[i])
                hit_val = hit_val | slot_val_reg[i];
        end
    end

    assign better = !vic_found_reg
                    || (slot_cnt_reg[scan_idx_reg] < vic_cnt_reg)
                    || ((slot_cnt_reg[scan_idx_reg] == vic_cnt_reg)
                        && (slot_rank_reg[scan_idx_reg] > vic_rank_reg));

    assign stat.cap_zero  = (cap_reg == '0);
    assign stat.hit       = |match_vec;
    assign stat.is_put    = (cmd_reg == CMD_PUT);
    assign stat.scan_last = (scan_idx_reg == LAST_IDX);
    assign stat.out_busy  = out_valid && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_data;
    end

    // request, search and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg       <= in_cmd;
            key_reg       <= in_key;
            val_reg       <= in_value;
            res_hit_reg   <= 1'b0;
            res_ev_reg    <= 1'b0;
            res_rd_reg    <= '0;
            res_evkey_reg <= '0;
        end
        if (cmd.match)
        begin
            match_reg      <= match_vec;
            hit_rank_reg   <= hit_rank;
            res_hit_reg    <= !stat.cap_zero && stat.hit;
            scan_idx_reg   <= '0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        if (cmd.update && cmd_reg == CMD_GET)
            res_rd_reg <= hit_val;
        if (cmd.scan)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (slot_valid_reg[scan_idx_reg])
            begin
                if (better)
                begin
                    vic_found_reg <= 1'b1;
                    vic_idx_reg   <= scan_idx_reg;
                    vic_cnt_reg   <= slot_cnt_reg[scan_idx_reg];
                    vic_rank_reg  <= slot_rank_reg[scan_idx_reg];
                    vic_key_reg   <= slot_key_reg[scan_idx_reg];
                end
            end
            else if (!free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= scan_idx_reg;
            end
        end
        if (cmd.evict && do_evict)
        begin
            res_ev_reg    <= 1'b1;
            res_evkey_reg <= vic_key_reg;
            if (!free_found_reg || vic_idx_reg < free_idx_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= vic_idx_reg;
            end
        end
    end

    // slot store: every lane updates itself
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
                slot_valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (cmd.evict && do_evict)
                occ_reg <= occ_reg - 1'b1;
            if (cmd.insert && free_found_reg)
                occ_reg <= occ_reg + 1'b1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (cmd.evict && do_evict && IDX_W'(i) == vic_idx_reg)
                    slot_valid_reg[i] <= 1'b0;
                if (cmd.insert && free_found_reg && IDX_W'(i) == free_idx_reg)
                    slot_valid_reg[i] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cmd.update && slot_valid_reg[i])
            begin
                if (match_reg[i])
                begin
                    slot_rank_reg[i] <= '0;
                    if (slot_cnt_reg[i] != '1)
                        slot_cnt_reg[i] <= slot_cnt_reg[i] + 1'b1;
                    if (cmd_reg == CMD_PUT)
                        slot_val_reg[i] <= val_reg;
                end
                else if (slot_rank_reg[i] < hit_rank_reg)
                    slot_rank_reg[i] <= slot_rank_reg[i] + 1'b1;
            end
            if (cmd.evict && do_evict && slot_valid_reg[i]
                && slot_rank_reg[i] > vic_rank_reg)
                slot_rank_reg[i] <= slot_rank_reg[i] - 1'b1;
            if (cmd.insert && free_found_reg)
            begin
                if (IDX_W'(i) == free_idx_reg)
                begin
                    slot_key_reg[i]  <= key_reg;
                    slot_val_reg[i]  <= val_reg;
                    slot_cnt_reg[i]  <= COUNT_BITS'(1);
                    slot_rank_reg[i] <= '0;
                end
                else if (slot_valid_reg[i])
                    slot_rank_reg[i] <= slot_rank_reg[i] + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.load_out)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_hit         <= res_hit_reg;
            out_read_value  <= res_rd_reg;
            out_evicted     <= res_ev_reg;
            out_evicted_key <= res_evkey_reg;
        end
    end

endmodule
`default_nettype wire

/* design/lfu_cache_table_unit.sv */
// States from the accepted beat to the result: MATCH, DONE for a get miss or any request at
// zero capacity; MATCH, UPDATE, DONE for a hit; MATCH, SCAN, EVICT, INSERT, DONE for a put miss;
// a put miss scans the slot store one slot per cycle for the victim and the first free slot.
// Throughput: one request at a time; the next beat is taken once the result is loaded.
// Reset: asynchronous, active low; clears slot valid bits, occupancy, state and the
// output valid; capacity returns to 16.
`default_nettype none
module lfu_cache_table_unit #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lfu_req_if.sink   in_ch,
    lfu_rsp_if.source out_ch,
    lfu_cfg_if.sink   cfg_ch
);
    import lfu_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [KEY_W-1:0] rd_value, ev_key;

    assign cfg_ch.ready = 1'b1;
    assign out_ch.read_value  = rd_value;
    assign out_ch.evicted_key = ev_key;

    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfu_datapath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_ch.valid),
        .cfg_data        (cfg_ch.data),
        .in_cmd          (in_ch.cmd),
        .in_key          (in_ch.key),
        .in_value        (in_ch.value),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_hit         (out_ch.hit),
        .out_read_value  (rd_value),
        .out_evicted     (out_ch.evicted),
        .out_evicted_key (ev_key)
    );

endmodule
`default_nettype wire

/* design/lfu_checker.sv */
`default_nettype none
module lfu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        hit,
    input wire logic [31:0] read_value,
    input wire logic        evicted,
    input wire logic [31:0] evicted_key
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value))
        else $error("result beat dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while one is in progress");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> read_value == 32'd0)
        else $error("miss returned a nonzero value");

    a_evict_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !hit)
        else $error("eviction reported on a hit");

    a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> evicted_key == 32'd0)
        else $error("evicted key set without eviction");

endmodule

bind lfu_cache_table_unit lfu_checker u_lfu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .hit         (out_ch.hit),
    .read_value  (out_ch.read_value),
    .evicted     (out_ch.evicted),
    .evicted_key (out_ch.evicted_key)
);
`default_nettype wire
